/* design/pbmq_pkg.sv */
// shared types and codes for the per-box message queues
package pbmq_pkg;

   // operation codes
   localparam logic OP_POST = 1'b0;
   localparam logic OP_RECV = 1'b1;

   // result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // fixed field widths
   localparam int BOX_ID_W = 4;
   localparam int HANDLE_W = 8;
   localparam int STATUS_W = 2;

   // highest number of boxes that a box id can reach
   localparam int BOX_ID_SPAN = 1 << BOX_ID_W;

   typedef logic [BOX_ID_W-1:0] box_id_type;
   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [STATUS_W-1:0] status_type;

endpackage

/* design/pbmq_if.sv */
// request and response channel interfaces
interface pbmq_req_if
   import pbmq_pkg::*;
();
   logic       valid;
   logic       ready;
   logic       operation;
   box_id_type box_id;
   handle_type message_handle;

   modport source (output valid, operation, box_id, message_handle, input ready);
   modport sink   (input valid, operation, box_id, message_handle, output ready);
endinterface

interface pbmq_rsp_if
   import pbmq_pkg::*;
();
   logic       valid;
   logic       ready;
   status_type status;
   handle_type handle_out;

   modport source (output valid, status, handle_out, input ready);
   modport sink   (input valid, status, handle_out, output ready);
endinterface

/* design/per_box_message_queues_core.sv */
// bank of per-box ring fifos of message handles, one post or receive per transfer
// result valid in the cycle after the request transfer
// throughput: one transfer per cycle while the response side takes results
// the slot memory is read and written in the transfer cycle, read data registered
// reset: synchronous, clears pointers, fill counts and the result valid flag
// slot memory is not cleared, only written entries are ever read
module per_box_message_queues_core
   import pbmq_pkg::*;
#(
   parameter int BOX_COUNT     = 16,
   parameter int SLOTS_PER_BOX = 8
) (
   input  logic      clock,
   input  logic      reset,
   pbmq_req_if.sink  req_ch,
   pbmq_rsp_if.source rsp_ch
);

   // boxes that a box id can actually address
   localparam int NUM_BOXES  = (BOX_COUNT < BOX_ID_SPAN) ? BOX_COUNT : BOX_ID_SPAN;
   localparam int BIDX_W     = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
   localparam int PTR_W      = (SLOTS_PER_BOX > 1) ? $clog2(SLOTS_PER_BOX) : 1;
   localparam int CNT_W      = $clog2(SLOTS_PER_BOX + 1);
   localparam int SLOT_TOTAL = NUM_BOXES * SLOTS_PER_BOX;
   localparam int ADDR_W     = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;

   // per-box state
   logic [PTR_W-1:0] wr_ptr_ff [NUM_BOXES];
   logic [PTR_W-1:0] rd_ptr_ff [NUM_BOXES];
   logic [CNT_W-1:0] count_ff  [NUM_BOXES];

   // slot memory and its registered read data
   handle_type slot_mem [SLOT_TOTAL];
   handle_type rd_data_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   status_type status_ff, status_in;
   logic       take_ff, take_in;

   logic              accept;
   logic [BIDX_W-1:0] box_idx;
   logic              box_ok;
   logic [PTR_W-1:0]  cur_wr, cur_rd, next_wr, next_rd;
   logic [CNT_W-1:0]  cur_cnt;
   logic              is_full, is_empty;
   logic              do_post, do_recv;
   logic [ADDR_W-1:0] addr;

   // handshake
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // box lookup and decision
   always_comb begin
      box_idx  = req_ch.box_id[BIDX_W-1:0];
      box_ok   = ({1'b0, req_ch.box_id} < (BOX_ID_W + 1)'(NUM_BOXES));
      cur_wr   = wr_ptr_ff[box_idx];
      cur_rd   = rd_ptr_ff[box_idx];
      cur_cnt  = count_ff[box_idx];
      is_full  = (cur_cnt == CNT_W'(SLOTS_PER_BOX));
      is_empty = (cur_cnt == '0);
      next_wr  = (cur_wr == PTR_W'(SLOTS_PER_BOX - 1)) ? '0 : cur_wr + 1'b1;
      next_rd  = (cur_rd == PTR_W'(SLOTS_PER_BOX - 1)) ? '0 : cur_rd + 1'b1;
      do_post  = accept && (req_ch.operation == OP_POST) && box_ok && !is_full;
      do_recv  = accept && (req_ch.operation == OP_RECV) && box_ok && !is_empty;
      addr     = ADDR_W'(box_idx * SLOTS_PER_BOX)
               + ADDR_W'((req_ch.operation == OP_POST) ? cur_wr : cur_rd);
      if (req_ch.operation == OP_POST) begin
         status_in = (do_post) ? ST_DONE : ST_FULL;
      end else begin
         status_in = (do_recv) ? ST_DONE : ST_EMPTY;
      end
      take_in = do_recv;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // pointer, count and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_BOXES; i++) begin
            wr_ptr_ff[i] <= '0;
            rd_ptr_ff[i] <= '0;
            count_ff[i]  <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (do_post) begin
            wr_ptr_ff[box_idx] <= next_wr;
            count_ff[box_idx]  <= cur_cnt + 1'b1;
         end
         if (do_recv) begin
            rd_ptr_ff[box_idx] <= next_rd;
            count_ff[box_idx]  <= cur_cnt - 1'b1;
         end
      end
   end

   // result payload, loaded on each transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         take_ff   <= take_in;
      end
   end

   // slot memory, one access per transfer
   always_ff @(posedge clock) begin
      if (do_post) begin
         slot_mem[addr] <= req_ch.message_handle;
      end
      if (do_recv) begin
         rd_data_ff <= slot_mem[addr];
      end
   end

   // response outputs
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.handle_out = take_ff ? rd_data_ff : '0;

endmodule
